@@ rtl/ole_pkg.sv @@
package ole_pkg;

    // List capacity and the widths that follow from it.
    localparam int DEPTH  = 16;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // Fixed field widths of the command and result transfers.
    localparam int VAL_W  = 32;
    localparam int POS_W  = 10;
    localparam int STAT_W = 3;
    localparam int ECNT_W = 5;

    // Working width for position and count arithmetic: holds count + 2 at this depth.
    localparam int EXT_W  = POS_W + 1;

    typedef enum logic [2:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_BACK  = 3'd1,
        OP_INS_AT    = 3'd2,
        OP_DEL_FRONT = 3'd3,
        OP_DEL_BACK  = 3'd4,
        OP_DEL_AT    = 3'd5,
        OP_SEARCH    = 3'd6,
        OP_DUMP      = 3'd7
    } t_opcode;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_INVALID  = 3'd2,
        ST_FULL     = 3'd3,
        ST_NOTFOUND = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_WR,
        S_INS_PUT,
        S_DEL_RD,
        S_DEL_CAP,
        S_SHF_RD,
        S_SHF_WR,
        S_SCN_RD,
        S_SCN_CHK
    } t_state;

    typedef struct packed {
        t_opcode                  opcode;
        logic signed [VAL_W-1:0]  value;
        logic        [POS_W-1:0]  position;
    } t_cmd;

    typedef struct packed {
        t_status                  status;
        logic signed [VAL_W-1:0]  item_value;
        logic        [POS_W-1:0]  item_position;
        logic        [ECNT_W-1:0] entry_count;
        logic                     last;
    } t_result;

    // Request from the sequencer to the element store.
    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [VAL_W-1:0]  wdata;
        logic [IDX_W-1:0]  raddr;
    } t_mem_req;

    function automatic logic [EXT_W-1:0] ext_cnt(input logic [CNT_W-1:0] c);
        return {{(EXT_W - CNT_W){1'b0}}, c};
    endfunction

    function automatic logic [EXT_W-1:0] ext_idx(input logic [IDX_W-1:0] i);
        return {{(EXT_W - IDX_W){1'b0}}, i};
    endfunction

    // Element count as carried on the result, masked to the field width.
    function automatic logic [ECNT_W-1:0] to_ecnt(input logic [CNT_W-1:0] c);
        logic [EXT_W-1:0] t;
        t = ext_cnt(c);
        return t[ECNT_W-1:0];
    endfunction

endpackage

@@ rtl/ole_ram.sv @@
module ole_ram
    import ole_pkg::*;
(
    input  logic              i_clk,
    input  t_mem_req          i_req,
    output logic [VAL_W-1:0]  o_rdata
);

    logic [VAL_W-1:0] r_mem [DEPTH];
    logic [VAL_W-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/ole_ctrl.sv @@
module ole_ctrl
    import ole_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  t_cmd              i_cmd,
    output logic              o_busy,
    output t_mem_req          o_mem,
    input  logic [VAL_W-1:0]  i_rdata,
    output logic              o_res_valid,
    output t_result           o_res
);

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    t_cmd              r_cmd, n_cmd;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [IDX_W-1:0]  r_tgt, n_tgt;
    logic [VAL_W-1:0]  r_val, n_val;

    logic [EXT_W-1:0]  cnt_x;
    logic [EXT_W-1:0]  pos_x;
    logic [EXT_W-1:0]  pos_m1;
    logic [EXT_W-1:0]  idx_x;
    logic [EXT_W-1:0]  cnt_m1;
    logic [EXT_W-1:0]  pos_out;

    // Shared index arithmetic for the current command.
    assign cnt_x   = ext_cnt(r_count);
    assign pos_x   = {1'b0, i_cmd.position};
    assign pos_m1  = pos_x - EXT_W'(1);
    assign idx_x   = ext_idx(r_idx);
    assign cnt_m1  = cnt_x - EXT_W'(1);
    assign pos_out = idx_x + EXT_W'(1);

    // State and datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_cmd <= n_cmd;
        r_idx <= n_idx;
        r_tgt <= n_tgt;
        r_val <= n_val;
    end

    // Sequencer: decode, shift loops, scan loop and result generation.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_cmd       = r_cmd;
        n_idx       = r_idx;
        n_tgt       = r_tgt;
        n_val       = r_val;
        o_mem       = '0;
        o_res_valid = 1'b0;
        o_res       = '0;
        o_res.status = ST_OK;
        o_res.last   = 1'b1;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_cmd = i_cmd;
                    case (i_cmd.opcode)
                        OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
                            if (i_cmd.opcode == OP_INS_AT &&
                                (pos_x == '0 || pos_x > cnt_x + EXT_W'(1))) begin
                                o_res_valid  = 1'b1;
                                o_res.status = ST_INVALID;
                            end else if (cnt_x >= EXT_W'(DEPTH)) begin
                                o_res_valid  = 1'b1;
                                o_res.status = ST_FULL;
                            end else begin
                                if (i_cmd.opcode == OP_INS_FRONT) begin
                                    n_tgt = '0;
                                end else if (i_cmd.opcode == OP_INS_BACK) begin
                                    n_tgt = cnt_x[IDX_W-1:0];
                                end else begin
                                    n_tgt = pos_m1[IDX_W-1:0];
                                end
                                n_idx = cnt_x[IDX_W-1:0];
                                if (ext_idx(n_tgt) == cnt_x) begin
                                    n_state = S_INS_PUT;
                                end else begin
                                    n_state = S_INS_RD;
                                end
                            end
                        end
                        OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_AT: begin
                            if (r_count == '0) begin
                                o_res_valid  = 1'b1;
                                o_res.status = ST_EMPTY;
                            end else if (i_cmd.opcode == OP_DEL_AT &&
                                         (pos_x == '0 || pos_x > cnt_x)) begin
                                o_res_valid  = 1'b1;
                                o_res.status = ST_INVALID;
                            end else begin
                                if (i_cmd.opcode == OP_DEL_FRONT) begin
                                    n_tgt = '0;
                                end else if (i_cmd.opcode == OP_DEL_BACK) begin
                                    n_tgt = cnt_m1[IDX_W-1:0];
                                end else begin
                                    n_tgt = pos_m1[IDX_W-1:0];
                                end
                                n_state = S_DEL_RD;
                            end
                        end
                        default: begin
                            // Search and dump both walk the list from the front.
                            if (r_count == '0) begin
                                o_res_valid  = 1'b1;
                                o_res.status = ST_EMPTY;
                            end else begin
                                n_idx   = '0;
                                n_state = S_SCN_RD;
                            end
                        end
                    endcase
                    o_res.entry_count = to_ecnt(r_count);
                end
            end

            // Open a gap by moving entries one place towards the back.
            S_INS_RD: begin
                o_mem.raddr = r_idx - IDX_W'(1);
                n_state     = S_INS_WR;
            end
            S_INS_WR: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_idx;
                o_mem.wdata = i_rdata;
                n_idx       = r_idx - IDX_W'(1);
                if (n_idx == r_tgt) begin
                    n_state = S_INS_PUT;
                end else begin
                    n_state = S_INS_RD;
                end
            end
            S_INS_PUT: begin
                o_mem.we          = 1'b1;
                o_mem.waddr       = r_tgt;
                o_mem.wdata       = $unsigned(r_cmd.value);
                n_count           = r_count + CNT_W'(1);
                o_res_valid       = 1'b1;
                o_res.entry_count = to_ecnt(n_count);
                n_state           = S_IDLE;
            end

            // Capture the deleted entry, then close the gap.
            S_DEL_RD: begin
                o_mem.raddr = r_tgt;
                n_state     = S_DEL_CAP;
            end
            S_DEL_CAP: begin
                n_val = i_rdata;
                n_idx = r_tgt;
                if (ext_idx(r_tgt) + EXT_W'(1) < cnt_x) begin
                    n_state = S_SHF_RD;
                end else begin
                    n_count           = r_count - CNT_W'(1);
                    o_res_valid       = 1'b1;
                    o_res.item_value  = $signed(i_rdata);
                    o_res.entry_count = to_ecnt(n_count);
                    n_state           = S_IDLE;
                end
            end
            S_SHF_RD: begin
                o_mem.raddr = r_idx + IDX_W'(1);
                n_state     = S_SHF_WR;
            end
            S_SHF_WR: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_idx;
                o_mem.wdata = i_rdata;
                n_idx       = r_idx + IDX_W'(1);
                if (idx_x + EXT_W'(2) < cnt_x) begin
                    n_state = S_SHF_RD;
                end else begin
                    n_count           = r_count - CNT_W'(1);
                    o_res_valid       = 1'b1;
                    o_res.item_value  = $signed(r_val);
                    o_res.entry_count = to_ecnt(n_count);
                    n_state           = S_IDLE;
                end
            end

            // Walk the list one entry at a time; a search compares each entry with the command value.
            S_SCN_RD: begin
                o_mem.raddr = r_idx;
                n_state     = S_SCN_CHK;
            end
            S_SCN_CHK: begin
                o_res.entry_count = to_ecnt(r_count);
                n_idx             = r_idx + IDX_W'(1);
                n_state           = S_SCN_RD;
                if (r_cmd.opcode == OP_SEARCH) begin
                    if (i_rdata == $unsigned(r_cmd.value)) begin
                        o_res_valid         = 1'b1;
                        o_res.item_value    = r_cmd.value;
                        o_res.item_position = pos_out[POS_W-1:0];
                        n_state             = S_IDLE;
                    end else if (pos_out == cnt_x) begin
                        o_res_valid  = 1'b1;
                        o_res.status = ST_NOTFOUND;
                        n_state      = S_IDLE;
                    end
                end else begin
                    o_res_valid         = 1'b1;
                    o_res.item_value    = $signed(i_rdata);
                    o_res.item_position = pos_out[POS_W-1:0];
                    o_res.last          = (pos_out == cnt_x);
                    if (pos_out == cnt_x) begin
                        n_state = S_IDLE;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

    // The element count never exceeds the capacity.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ext_cnt(r_count) <= EXT_W'(DEPTH))
        else $error("element count above capacity");

    // The count changes only together with a result.
    a_count_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_res_valid |=> $stable(r_count))
        else $error("element count changed without a result");

    // The final result of a command returns the sequencer to idle.
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.last |=> r_state == S_IDLE)
        else $error("sequencer busy after final result");

    // A result that is not the final one only comes from a dump that continues.
    a_more_dump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_res.last |=> r_state == S_SCN_RD && r_cmd.opcode == OP_DUMP)
        else $error("non-final result outside a dump");

    // The store is written only while a command is in progress.
    a_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem.we |-> o_busy)
        else $error("store written while idle");

endmodule

@@ rtl/ordered_list_engine_core.sv @@
// An error result appears in the cycle after the command transfer. Search and dump visit
// the elements from the front; insert and delete at 0-based place k shift the elements
// between place k and the back of the list. Every element move is a read and then a write
// of the element store through its registered read port. A new command is taken the cycle
// busy falls, so one command is in flight at a time. Synchronous active-low reset empties
// the list; the store is not cleared.
module ordered_list_engine_core
    import ole_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_cmd     i_cmd,
    output logic     o_strobe,
    output t_result  o_result
);

    t_mem_req          mem_req;
    logic [VAL_W-1:0]  mem_rdata;
    logic              res_valid;
    t_result           res;
    logic              ctrl_busy;
    logic              r_strobe;
    t_result           r_result;

    ole_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_cmd       (i_cmd),
        .o_busy      (ctrl_busy),
        .o_mem       (mem_req),
        .i_rdata     (mem_rdata),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    ole_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    // Result register: each result transfer is shown for one cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= res_valid;
        end
        if (res_valid) begin
            r_result <= res;
        end
    end

    assign busy     = ctrl_busy;
    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

@@ sim/tb_ordered_list_engine_core.sv @@
`timescale 1ns / 1ps

module tb_ordered_list_engine_core;
    import ole_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 2 * DEPTH + 8;

    logic    i_clk;
    logic    i_rst_n;
    logic    start;
    logic    busy;
    t_cmd    i_cmd;
    logic    o_strobe;
    t_result o_result;

    ordered_list_engine_core uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (i_cmd),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // Commands waiting to be driven and results the list should produce.
    t_cmd    pending_cmds[$];
    t_result expected_results[$];

    // Shadow copy of the list, updated at each command transfer.
    logic signed [VAL_W-1:0] model_list[DEPTH];
    int                      model_count;

    // List length as the stimulus planner expects it once all planned commands have run.
    int planned_count;

    logic signed [VAL_W-1:0] value_pool[8];
    int  idle_pct;
    bit  cmd_taken;
    int  mismatches;
    int  quiet_cycles;
    int  cmds_sent;
    int  results_seen;
    int  status_seen[5];

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Queue one expected result; the count field reflects the list after the command.
    task automatic expect_result(input t_status st, input logic signed [VAL_W-1:0] val,
                                 input int pos, input bit fin);
        t_result r;
        r.status        = st;
        r.item_value    = val;
        r.item_position = POS_W'(pos);
        r.entry_count   = ECNT_W'(model_count);
        r.last          = fin;
        expected_results.push_back(r);
    endtask

    // Work out the results of one command and apply it to the shadow list.
    task automatic predict_list_cmd(input t_cmd c);
        int slot;
        int i;
        bit found;
        found = 1'b0;
        case (c.opcode)
            OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
                if (c.opcode == OP_INS_AT &&
                    (c.position == 0 || int'(c.position) > model_count + 1)) begin
                    expect_result(ST_INVALID, '0, 0, 1'b1);
                end else if (model_count >= DEPTH) begin
                    expect_result(ST_FULL, '0, 0, 1'b1);
                end else begin
                    if (c.opcode == OP_INS_FRONT)
                        slot = 0;
                    else if (c.opcode == OP_INS_BACK)
                        slot = model_count;
                    else
                        slot = int'(c.position) - 1;
                    for (i = model_count; i > slot; i--)
                        model_list[i] = model_list[i-1];
                    model_list[slot] = c.value;
                    model_count++;
                    expect_result(ST_OK, '0, 0, 1'b1);
                end
            end
            OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_AT: begin
                if (model_count == 0) begin
                    expect_result(ST_EMPTY, '0, 0, 1'b1);
                end else if (c.opcode == OP_DEL_AT &&
                             (c.position == 0 || int'(c.position) > model_count)) begin
                    expect_result(ST_INVALID, '0, 0, 1'b1);
                end else begin
                    if (c.opcode == OP_DEL_FRONT)
                        slot = 0;
                    else if (c.opcode == OP_DEL_BACK)
                        slot = model_count - 1;
                    else
                        slot = int'(c.position) - 1;
                    expect_result(ST_OK, model_list[slot], 0, 1'b1);
                    for (i = slot; i + 1 < model_count; i++)
                        model_list[i] = model_list[i+1];
                    model_count--;
                    // The count field must show the shortened list.
                    expected_results[$].entry_count = ECNT_W'(model_count);
                end
            end
            OP_SEARCH: begin
                if (model_count == 0) begin
                    expect_result(ST_EMPTY, '0, 0, 1'b1);
                end else begin
                    for (i = 0; i < model_count && !found; i++) begin
                        if (model_list[i] == c.value) begin
                            expect_result(ST_OK, c.value, i + 1, 1'b1);
                            found = 1'b1;
                        end
                    end
                    if (!found)
                        expect_result(ST_NOTFOUND, '0, 0, 1'b1);
                end
            end
            default: begin
                if (model_count == 0) begin
                    expect_result(ST_EMPTY, '0, 0, 1'b1);
                end else begin
                    for (i = 0; i < model_count; i++)
                        expect_result(ST_OK, model_list[i], i + 1, i + 1 == model_count);
                end
            end
        endcase
    endtask

    // Queue a command and track the list length it leaves behind.
    task automatic plan_cmd(input t_opcode op, input logic signed [VAL_W-1:0] v,
                            input logic [POS_W-1:0] p);
        t_cmd c;
        c.opcode   = op;
        c.value    = v;
        c.position = p;
        pending_cmds.push_back(c);
        if (op == OP_INS_FRONT || op == OP_INS_BACK || op == OP_INS_AT) begin
            if ((op != OP_INS_AT || (p != 0 && int'(p) <= planned_count + 1)) &&
                planned_count < DEPTH)
                planned_count++;
        end else if (op == OP_DEL_FRONT || op == OP_DEL_BACK || op == OP_DEL_AT) begin
            if (planned_count > 0 && (op != OP_DEL_AT || (p != 0 && int'(p) <= planned_count)))
                planned_count--;
        end
    endtask

    // Random commands in runs of sixteen that tend to grow, shrink or churn the list.
    task automatic plan_random_cmds(input int n, input int grow_first);
        int k;
        int trend;
        int roll;
        int ins_th;
        int del_th;
        int srch_th;
        int lim;
        t_opcode op;
        logic signed [VAL_W-1:0] v;
        logic [POS_W-1:0] p;
        trend = 2;
        for (k = 0; k < n; k++) begin
            if (k % 16 == 0)
                trend = (k < grow_first) ? 0 : $urandom_range(2);
            case (trend)
                0:       begin ins_th = 80; del_th = 85; srch_th = 95; end
                1:       begin ins_th = 10; del_th = 85; srch_th = 95; end
                default: begin ins_th = 35; del_th = 70; srch_th = 90; end
            endcase
            roll = $urandom_range(99);
            if (roll < ins_th)
                op = t_opcode'($urandom_range(2));
            else if (roll < del_th)
                op = t_opcode'(3 + $urandom_range(2));
            else if (roll < srch_th)
                op = OP_SEARCH;
            else
                op = OP_DUMP;

            // Values mostly come from a small pool so that searches find matches.
            v = ($urandom_range(9) < 6) ? value_pool[$urandom_range(7)] : $urandom;

            // Mostly legal positions, with zero, one past the end and wide values mixed in.
            lim  = (op == OP_INS_AT) ? planned_count + 1 : planned_count;
            roll = $urandom_range(9);
            if ((op == OP_INS_AT || op == OP_DEL_AT) && lim > 0 && roll < 7)
                p = POS_W'($urandom_range(lim, 1));
            else if (roll == 7)
                p = '0;
            else if (roll == 8)
                p = POS_W'(lim + 1);
            else
                p = POS_W'($urandom_range(1023));
            plan_cmd(op, v, p);
        end
    endtask

    task automatic check_field(input string what, input logic [VAL_W-1:0] want,
                               input logic [VAL_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
            mismatches++;
        end
    endtask

    // Driver: presents the next command at the falling edge and holds it until transfer.
    always @(negedge i_clk) begin
        logic [63:0] noise_bits;
        if (!(start && !cmd_taken)) begin
            cmd_taken = 1'b0;
            if (pending_cmds.size() != 0 && $urandom_range(99) >= idle_pct) begin
                start <= 1'b1;
                i_cmd <= pending_cmds.pop_front();
            end else begin
                // Idle cycle: random contents on the command bus must be ignored.
                noise_bits = {$urandom, $urandom};
                start <= 1'b0;
                i_cmd <= t_cmd'(noise_bits[$bits(t_cmd)-1:0]);
            end
        end
    end

    // Monitor: checks results, predicts on each command transfer and guards against hangs.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if (o_strobe) begin
                results_seen++;
                if (o_result.status <= ST_NOTFOUND)
                    status_seen[o_result.status]++;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result: expected none, got %p", $time, o_result);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", VAL_W'(want.status), VAL_W'(o_result.status));
                    check_field("item_value", want.item_value, o_result.item_value);
                    check_field("item_position", VAL_W'(want.item_position),
                                VAL_W'(o_result.item_position));
                    check_field("entry_count", VAL_W'(want.entry_count),
                                VAL_W'(o_result.entry_count));
                    check_field("last", VAL_W'(want.last), VAL_W'(o_result.last));
                end
            end
            if (start && !busy) begin
                cmd_taken = 1'b1;
                cmds_sent++;
                predict_list_cmd(i_cmd);
            end
            if (o_strobe || (start && !busy))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no transfer for %0d cycles, %0d commands and %0d results pending",
                         $time, quiet_cycles, pending_cmds.size(), expected_results.size());
                $display("tb_ordered_list_engine_core: FAIL");
                $finish;
            end
        end
    end

    // Stimulus: reset, a directed sequence, then random commands under three pacing schemes.
    initial begin
        int phase;
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_cmd         = '0;
        cmd_taken     = 1'b0;
        idle_pct      = 14;
        model_count   = 0;
        planned_count = 0;
        mismatches    = 0;
        quiet_cycles  = 0;
        cmds_sent     = 0;
        results_seen  = 0;
        status_seen   = '{default: 0};
        value_pool    = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0, -32'sd1,
                          $urandom, $urandom, $urandom, $urandom};

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty-list cases and out-of-range insert positions.
        plan_cmd(OP_SEARCH, 32'sd5, 10'd0);
        plan_cmd(OP_DUMP, 32'sd0, 10'd0);
        plan_cmd(OP_DEL_FRONT, 32'sd0, 10'd0);
        plan_cmd(OP_DEL_BACK, 32'sd0, 10'd0);
        plan_cmd(OP_DEL_AT, 32'sd0, 10'd0);
        plan_cmd(OP_INS_AT, 32'sd1, 10'd0);
        plan_cmd(OP_INS_AT, 32'sd1, 10'd2);
        plan_cmd(OP_INS_AT, 32'sd1, 10'd1023);
        // Build a five-element list with the value extremes at every kind of insert.
        plan_cmd(OP_INS_FRONT, 32'sh7FFF_FFFF, 10'd0);
        plan_cmd(OP_INS_BACK, 32'sh8000_0000, 10'd0);
        plan_cmd(OP_INS_AT, -32'sd1, 10'd2);
        plan_cmd(OP_INS_AT, 32'sd0, 10'd4);
        plan_cmd(OP_INS_AT, 32'sh5A5A_5A5A, 10'd1);
        // Search hits in the middle and at the end, a miss, then a full dump.
        plan_cmd(OP_SEARCH, -32'sd1, 10'd1023);
        plan_cmd(OP_SEARCH, 32'sd0, 10'd0);
        plan_cmd(OP_SEARCH, 32'sh1234_5678, 10'd0);
        plan_cmd(OP_DUMP, 32'sd0, 10'd0);
        // Delete position checks, then every kind of delete down to empty.
        plan_cmd(OP_DEL_AT, 32'sd0, 10'd0);
        plan_cmd(OP_DEL_AT, 32'sd0, 10'd6);
        plan_cmd(OP_DEL_AT, 32'sd0, 10'd3);
        plan_cmd(OP_DEL_FRONT, 32'sd0, 10'd0);
        plan_cmd(OP_DEL_BACK, 32'sd0, 10'd0);
        plan_cmd(OP_DEL_AT, 32'sd0, 10'd2);
        plan_cmd(OP_DEL_AT, 32'sd0, 10'd1);
        plan_cmd(OP_DUMP, 32'sd0, 10'd0);

        for (phase = 0; phase < 3; phase++) begin
            idle_pct = (phase == 0) ? 14 : ((phase == 1) ? 84 : 0);
            // The first random runs fill the list so that inserts into a full list occur.
            plan_random_cmds(phase == 0 ? 100 : 105, phase == 0 ? 48 : 0);
            while (pending_cmds.size() != 0 || start || expected_results.size() != 0)
                @(posedge i_clk);
        end

        // Allow time for any stray result to show up.
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Transferred %0d commands and checked %0d results across three pacing phases.",
                 cmds_sent, results_seen);
        $display("Statuses seen: ok %0d, empty %0d, invalid %0d, full %0d, not found %0d.",
                 status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_INVALID],
                 status_seen[ST_FULL], status_seen[ST_NOTFOUND]);
        if (mismatches == 0)
            $display("tb_ordered_list_engine_core: PASS");
        else
            $display("tb_ordered_list_engine_core: FAIL");
        $finish;
    end

endmodule
